// ===== sv/sphere_pair_elastic_collision_unit_macros.svh =====
// assertion helpers for the collision unit
`ifndef SPHERE_PAIR_ELASTIC_COLLISION_UNIT_MACROS_SVH
`define SPHERE_PAIR_ELASTIC_COLLISION_UNIT_MACROS_SVH

// same-cycle implication
`define SPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spc check failed");

// next-cycle implication
`define SPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spc check failed");

`endif

// ===== sv/spc_pkg.sv =====
package spc_pkg;

  // normalised offset magnitude and derived widths
  localparam int OMW       = 13;
  localparam int NNW       = 28;
  localparam int DVDW      = 62;
  localparam int QW        = 38;
  localparam int DIV_STEP  = 2;
  localparam int DIV_STAGES = QW / DIV_STEP;

  typedef enum logic [2:0] {
    CFG_REACH_SCALE   = 3'd0,
    CFG_VELOCITY_GAIN = 3'd1,
    CFG_BOUNCE        = 3'd2,
    CFG_HITSTOP_SPEED = 3'd3,
    CFG_HITSTOP_TICKS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [18:0] reach_scale;
    logic [18:0] gain;
    logic [16:0] bounce;
    logic [30:0] hs_speed;
    logic [7:0]  hs_ticks;
  } cfg_t;

  typedef struct packed {
    logic            kind;
    logic [2:0][31:0] offset;
    logic [30:0]     r1;
    logic [30:0]     r2;
    logic [2:0][31:0] v1;
    logic [2:0][31:0] v2;
  } in_item_t;

  typedef struct packed {
    logic [2:0][31:0]    v1;
    logic [2:0][31:0]    v2;
    logic [2:0][OMW-1:0] o_mag;
    logic [2:0]          o_neg;
    logic                hit;
    logic                zero;
    logic                hs;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [DVDW-1:0] dividend;
    logic [NNW-1:0]  nn;
    logic            q_neg;
  } div_in_t;

  typedef struct packed {
    logic            hit;
    logic [2:0][31:0] n1;
    logic [2:0][31:0] n2;
    logic [7:0]      hitstop;
  } out_item_t;

endpackage

// ===== sv/spc_if.sv =====
interface spc_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;
  logic [30:0]        radius_first;
  logic [30:0]        radius_second;
  logic signed [31:0] first_vel_x;
  logic signed [31:0] first_vel_y;
  logic signed [31:0] first_vel_z;
  logic signed [31:0] second_vel_x;
  logic signed [31:0] second_vel_y;
  logic signed [31:0] second_vel_z;

  modport source (
    output valid, kind, offset_x, offset_y, offset_z, radius_first, radius_second,
           first_vel_x, first_vel_y, first_vel_z, second_vel_x, second_vel_y, second_vel_z,
    input  ready
  );
  modport sink (
    input  valid, kind, offset_x, offset_y, offset_z, radius_first, radius_second,
           first_vel_x, first_vel_y, first_vel_z, second_vel_x, second_vel_y, second_vel_z,
    output ready
  );
endinterface

interface spc_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] new_first_x;
  logic signed [31:0] new_first_y;
  logic signed [31:0] new_first_z;
  logic signed [31:0] new_second_x;
  logic signed [31:0] new_second_y;
  logic signed [31:0] new_second_z;
  logic [7:0]         hitstop_time;

  modport source (
    output valid, hit, new_first_x, new_first_y, new_first_z,
           new_second_x, new_second_y, new_second_z, hitstop_time,
    input  ready
  );
  modport sink (
    input  valid, hit, new_first_x, new_first_y, new_first_z,
           new_second_x, new_second_y, new_second_z, hitstop_time,
    output ready
  );
endinterface

interface spc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/spc_front.sv =====
module spc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  spc_pkg::cfg_t     cfg_i,
  input  logic              valid_i,
  input  spc_pkg::in_item_t item_i,
  output logic              valid_o,
  output spc_pkg::div_in_t  div_o
);

  logic [4:0] vld_q;

  // stage 1: magnitudes, squares, velocity difference, radius sum
  logic [2:0][31:0] om1_d, om1_q;
  logic [2:0][63:0] sqo1_d, sqo1_q, sqv1_d, sqv1_q;
  logic [2:0][32:0] dv1_d, dv1_q;
  logic [2:0]       oneg1_q;
  logic [31:0]      reach1_d, reach1_q, m1_d, m1_q;
  logic             kind1_q;
  logic [2:0][31:0] va1_q, vb1_q;

  always_comb begin
    logic [31:0] vm;
    for (int i = 0; i < 3; i++) begin
      om1_d[i]  = item_i.offset[i][31] ? (~item_i.offset[i] + 32'd1) : item_i.offset[i];
      vm        = item_i.v1[i][31] ? (~item_i.v1[i] + 32'd1) : item_i.v1[i];
      sqo1_d[i] = 64'(om1_d[i]) * 64'(om1_d[i]);
      sqv1_d[i] = 64'(vm) * 64'(vm);
      dv1_d[i]  = {item_i.v2[i][31], item_i.v2[i]} - {item_i.v1[i][31], item_i.v1[i]};
    end
    m1_d = om1_d[0];
    if (om1_d[1] > m1_d) m1_d = om1_d[1];
    if (om1_d[2] > m1_d) m1_d = om1_d[2];
    reach1_d = 32'(item_i.r1) + 32'(item_i.r2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      om1_q    <= om1_d;
      sqo1_q   <= sqo1_d;
      sqv1_q   <= sqv1_d;
      dv1_q    <= dv1_d;
      for (int i = 0; i < 3; i++) oneg1_q[i] <= item_i.offset[i][31];
      reach1_q <= reach1_d;
      m1_q     <= m1_d;
      kind1_q  <= item_i.kind;
      va1_q    <= item_i.v1;
      vb1_q    <= item_i.v2;
    end
  end

  // stage 2: distance and speed sums, reach (scaled when kind is set), leading one of largest offset
  logic [63:0]      d2_2_d, d2_2_q, sp2_2_d, sp2_2_q;
  logic [34:0]      reach2_d, reach2_q;
  logic [4:0]       lead2_d, lead2_q;
  logic [61:0]      thr2_d, thr2_q;
  logic [2:0][31:0] om2_q;
  logic [2:0][32:0] dv2_q;
  logic [2:0]       oneg2_q;
  logic             kind2_q;
  logic [2:0][31:0] va2_q, vb2_q;

  always_comb begin
    d2_2_d  = sqo1_q[0] + sqo1_q[1] + sqo1_q[2];
    sp2_2_d = sqv1_q[0] + sqv1_q[1] + sqv1_q[2];
    if (kind1_q) begin
      reach2_d = 35'((51'(reach1_q) * 51'(cfg_i.reach_scale)) >> 16);
    end else begin
      reach2_d = 35'(reach1_q);
    end
    lead2_d = '0;
    for (int b = 0; b < 32; b++) begin
      if (m1_q[b]) lead2_d = 5'(b);
    end
    thr2_d = 62'(cfg_i.hs_speed) * 62'(cfg_i.hs_speed);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_2_q   <= d2_2_d;
      sp2_2_q  <= sp2_2_d;
      reach2_q <= reach2_d;
      lead2_q  <= lead2_d;
      thr2_q   <= thr2_d;
      om2_q    <= om1_q;
      dv2_q    <= dv1_q;
      oneg2_q  <= oneg1_q;
      kind2_q  <= kind1_q;
      va2_q    <= va1_q;
      vb2_q    <= vb1_q;
    end
  end

  // stage 3: reach squared, offset normalised to leading one at bit 12
  logic                   rbig3_q, spf3_q;
  logic [63:0]            rr3_d, rr3_q, d2_3_q;
  logic [2:0][spc_pkg::OMW-1:0] a3_d, a3_q;
  logic [2:0][32:0]       dv3_q;
  logic [2:0]             oneg3_q;
  logic [2:0][31:0]       va3_q, vb3_q;

  always_comb begin
    rr3_d = 64'(reach2_q[31:0]) * 64'(reach2_q[31:0]);
    for (int i = 0; i < 3; i++) begin
      if (lead2_q >= 5'd12) begin
        a3_d[i] = spc_pkg::OMW'(om2_q[i] >> (lead2_q - 5'd12));
      end else begin
        a3_d[i] = spc_pkg::OMW'(om2_q[i] << (5'd12 - lead2_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rbig3_q <= |reach2_q[34:32];
      rr3_q   <= rr3_d;
      spf3_q  <= kind2_q & (sp2_2_q > 64'(thr2_q));
      a3_q    <= a3_d;
      d2_3_q  <= d2_2_q;
      dv3_q   <= dv2_q;
      oneg3_q <= oneg2_q;
      va3_q   <= va2_q;
      vb3_q   <= vb2_q;
    end
  end

  // stage 4: hit decision, projection terms and normal length terms
  logic             hit4_d, hit4_q, zero4_q, hs4_q;
  logic [2:0][46:0] kt4_d, kt4_q;
  logic [2:0][25:0] sq4_d, sq4_q;
  logic [2:0][spc_pkg::OMW-1:0] a4_q;
  logic [2:0]       oneg4_q;
  logic [2:0][31:0] va4_q, vb4_q;

  always_comb begin
    logic signed [46:0] ox, dx;
    hit4_d = rbig3_q | (d2_3_q <= rr3_q);
    for (int i = 0; i < 3; i++) begin
      ox = 47'(a3_q[i]);
      if (oneg3_q[i]) ox = -ox;
      dx = 47'($signed(dv3_q[i]));
      kt4_d[i] = ox * dx;
      sq4_d[i] = 26'(a3_q[i]) * 26'(a3_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit4_q  <= hit4_d;
      zero4_q <= (d2_3_q == 64'd0);
      hs4_q   <= spf3_q & hit4_d;
      kt4_q   <= kt4_d;
      sq4_q   <= sq4_d;
      a4_q    <= a3_q;
      oneg4_q <= oneg3_q;
      va4_q   <= va3_q;
      vb4_q   <= vb3_q;
    end
  end

  // stage 5: dot product and norm sums, dividend set up for the divider
  spc_pkg::div_in_t div_d;

  always_comb begin
    logic signed [48:0] k;
    logic [48:0]        kmag;
    k = 49'($signed(kt4_q[0])) + 49'($signed(kt4_q[1])) + 49'($signed(kt4_q[2]));
    kmag = k[48] ? 49'(-k) : 49'(k);
    div_d.dividend   = {kmag[47:0], 14'd0};
    div_d.nn         = spc_pkg::NNW'(sq4_q[0]) + spc_pkg::NNW'(sq4_q[1])
                       + spc_pkg::NNW'(sq4_q[2]);
    div_d.q_neg      = k[48];
    div_d.side.v1    = va4_q;
    div_d.side.v2    = vb4_q;
    div_d.side.o_mag = a4_q;
    div_d.side.o_neg = oneg4_q;
    div_d.side.hit   = hit4_q;
    div_d.side.zero  = zero4_q;
    div_d.side.hs    = hs4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) div_o <= div_d;
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  assign valid_o = vld_q[4];

endmodule

// ===== sv/spc_div.sv =====
module spc_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  spc_pkg::div_in_t       div_i,
  output logic                   valid_o,
  output spc_pkg::side_t         side_o,
  output logic [spc_pkg::QW-1:0] qmag_o,
  output logic                   qneg_o
);

  localparam int NS = spc_pkg::DIV_STAGES;

  logic [NS-1:0]           vld_q;
  logic [spc_pkg::NNW-1:0] rem_d [NS];
  logic [spc_pkg::NNW-1:0] rem_q [NS];
  logic [spc_pkg::QW-1:0]  quo_d [NS];
  logic [spc_pkg::QW-1:0]  quo_q [NS];
  spc_pkg::div_in_t        pay_q [NS];

  // restoring division, two quotient bits per stage
  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [spc_pkg::NNW-1:0] rem_in;
    logic [spc_pkg::QW-1:0]  quo_in;
    spc_pkg::div_in_t        pay_in;

    if (s == 0) begin : g_first
      assign pay_in = div_i;
      assign rem_in = spc_pkg::NNW'(div_i.dividend[spc_pkg::DVDW-1:spc_pkg::QW]);
      assign quo_in = '0;
    end else begin : g_next
      assign pay_in = pay_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      logic [spc_pkg::NNW:0]   t;
      logic [spc_pkg::NNW-1:0] r;
      logic [spc_pkg::QW-1:0]  q;
      r = rem_in;
      q = quo_in;
      for (int b = 0; b < spc_pkg::DIV_STEP; b++) begin
        t = {r, pay_in.dividend[spc_pkg::QW-1-(s*spc_pkg::DIV_STEP+b)]};
        if (t >= {1'b0, pay_in.nn}) begin
          r = spc_pkg::NNW'(t - {1'b0, pay_in.nn});
          q = {q[spc_pkg::QW-2:0], 1'b1};
        end else begin
          r = t[spc_pkg::NNW-1:0];
          q = {q[spc_pkg::QW-2:0], 1'b0};
        end
      end
      rem_d[s] = r;
      quo_d[s] = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        pay_q[s] <= pay_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NS-1];
  assign side_o  = pay_q[NS-1].side;
  assign qneg_o  = pay_q[NS-1].q_neg;
  assign qmag_o  = quo_q[NS-1];

endmodule

// ===== sv/spc_back.sv =====
module spc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  spc_pkg::cfg_t          cfg_i,
  input  logic                   valid_i,
  input  spc_pkg::side_t         side_i,
  input  logic [spc_pkg::QW-1:0] qmag_i,
  input  logic                   qneg_i,
  output logic                   valid_o,
  output spc_pkg::out_item_t     item_o
);

  logic [4:0] vld_q;

  // stage 1: projection of offset onto quotient, truncated toward zero
  logic [2:0][36:0] pm1_d, pm1_q;
  logic [2:0]       pneg1_q;
  spc_pkg::side_t   side1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pm1_d[i] = 37'((51'(side_i.o_mag[i]) * 51'(qmag_i)) >> 14);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm1_q   <= pm1_d;
      pneg1_q <= side_i.o_neg ^ {3{qneg_i}};
      side1_q <= side_i;
    end
  end

  // stage 2: restitution factor
  logic [2:0][37:0] dl2_d, dl2_q;
  logic [2:0]       dneg2_q;
  spc_pkg::side_t   side2_q;

  always_comb begin
    logic [17:0] fac;
    fac = 18'(cfg_i.bounce) + 18'd65536;
    for (int i = 0; i < 3; i++) begin
      dl2_d[i] = 38'((55'(pm1_q[i]) * 55'(fac)) >> 17);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dl2_q   <= dl2_d;
      dneg2_q <= pneg1_q;
      side2_q <= side1_q;
    end
  end

  // stage 3: add and subtract the exchanged part, keep sign and magnitude
  logic [2:0][39:0] sm3_d, sm3_q;
  logic [2:0]       sn3_d, sn3_q;
  logic [2:0][39:0] sm3_d2, sm3_q2;
  logic [2:0]       sn3_d2, sn3_q2;
  spc_pkg::side_t   side3_q;

  always_comb begin
    logic signed [39:0] dl, s;
    for (int i = 0; i < 3; i++) begin
      dl = 40'(dl2_q[i]);
      if (dneg2_q[i]) dl = -dl;
      s = 40'($signed(side2_q.v1[i])) + dl;
      sn3_d[i]  = s[39];
      sm3_d[i]  = s[39] ? 40'(-s) : 40'(s);
      s = 40'($signed(side2_q.v2[i])) - dl;
      sn3_d2[i] = s[39];
      sm3_d2[i] = s[39] ? 40'(-s) : 40'(s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sm3_q   <= sm3_d;
      sn3_q   <= sn3_d;
      sm3_q2  <= sm3_d2;
      sn3_q2  <= sn3_d2;
      side3_q <= side2_q;
    end
  end

  // stage 4: velocity gain
  logic [2:0][42:0] g1_d, g1_q, g2_d, g2_q;
  logic [2:0]       gn1_q, gn2_q;
  spc_pkg::side_t   side4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g1_d[i] = 43'((59'(sm3_q[i]) * 59'(cfg_i.gain)) >> 16);
      g2_d[i] = 43'((59'(sm3_q2[i]) * 59'(cfg_i.gain)) >> 16);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_q    <= g1_d;
      g2_q    <= g2_d;
      gn1_q   <= sn3_q;
      gn2_q   <= sn3_q2;
      side4_q <= side3_q;
    end
  end

  // stage 5: saturate, pick pass-through on miss or zero offset
  function automatic logic [31:0] sat32(logic [42:0] mag, logic neg);
    logic signed [43:0] v;
    v = 44'(mag);
    if (neg) v = -v;
    if (v > 44'sd2147483647) begin
      sat32 = 32'h7fff_ffff;
    end else if (v < -44'sd2147483648) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  spc_pkg::out_item_t item_d;

  always_comb begin
    item_d.hit     = side4_q.hit;
    item_d.hitstop = side4_q.hs ? cfg_i.hs_ticks : 8'd0;
    for (int i = 0; i < 3; i++) begin
      if (side4_q.hit && !side4_q.zero) begin
        item_d.n1[i] = sat32(g1_q[i], gn1_q[i]);
        item_d.n2[i] = sat32(g2_q[i], gn2_q[i]);
      end else begin
        item_d.n1[i] = side4_q.v1[i];
        item_d.n2[i] = side4_q.v2[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) item_o <= item_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  assign valid_o = vld_q[4];

endmodule

// ===== sv/sphere_pair_elastic_collision_unit.sv =====
// channel   dir  handshake      payload
// in_i      in   valid/ready    pair: kind, offsets, radii, both velocities
// cfg_i     in   valid/ready    register index and write data
// out_o     out  valid/ready    hit, both new velocities, hit-stop time
//
// one pair per cycle sustained while the output is not stalled
// depth set by the divider: 19 stages at two quotient bits each, plus
// five stages in front and five behind
// reset clears valid bits and loads register defaults
// a stalled output holds the whole pipeline; ready falls only while a
// result waits untaken
`include "sphere_pair_elastic_collision_unit_macros.svh"

module sphere_pair_elastic_collision_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  spc_in_if.sink     in_i,
  spc_cfg_if.sink    cfg_i,
  spc_out_if.source  out_o
);

  spc_pkg::cfg_t cfg_q;
  logic          en;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reach_scale <= 19'd78643;
      cfg_q.gain        <= 19'd78643;
      cfg_q.bounce      <= 17'd65536;
      cfg_q.hs_speed    <= 31'd26214;
      cfg_q.hs_ticks    <= 8'd15;
    end else if (cfg_i.valid) begin
      unique case (spc_pkg::cfg_idx_e'(cfg_i.index))
        spc_pkg::CFG_REACH_SCALE:   cfg_q.reach_scale <= cfg_i.data[18:0];
        spc_pkg::CFG_VELOCITY_GAIN: cfg_q.gain        <= cfg_i.data[18:0];
        spc_pkg::CFG_BOUNCE:        cfg_q.bounce      <= cfg_i.data[16:0];
        spc_pkg::CFG_HITSTOP_SPEED: cfg_q.hs_speed    <= cfg_i.data[30:0];
        spc_pkg::CFG_HITSTOP_TICKS: cfg_q.hs_ticks    <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // pipeline advances unless the output register holds an untaken result
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  spc_pkg::in_item_t item;
  always_comb begin
    item.kind      = in_i.kind;
    item.offset[0] = in_i.offset_x;
    item.offset[1] = in_i.offset_y;
    item.offset[2] = in_i.offset_z;
    item.r1        = in_i.radius_first;
    item.r2        = in_i.radius_second;
    item.v1[0]     = in_i.first_vel_x;
    item.v1[1]     = in_i.first_vel_y;
    item.v1[2]     = in_i.first_vel_z;
    item.v2[0]     = in_i.second_vel_x;
    item.v2[1]     = in_i.second_vel_y;
    item.v2[2]     = in_i.second_vel_z;
  end

  logic                   f_valid, d_valid, b_valid;
  spc_pkg::div_in_t       f_div;
  spc_pkg::side_t         d_side;
  logic [spc_pkg::QW-1:0] d_qmag;
  logic                   d_qneg;
  spc_pkg::out_item_t     b_item;

  spc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (in_i.valid),
    .item_i  (item),
    .valid_o (f_valid),
    .div_o   (f_div)
  );

  spc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .div_i   (f_div),
    .valid_o (d_valid),
    .side_o  (d_side),
    .qmag_o  (d_qmag),
    .qneg_o  (d_qneg)
  );

  spc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (d_valid),
    .side_i  (d_side),
    .qmag_i  (d_qmag),
    .qneg_i  (d_qneg),
    .valid_o (b_valid),
    .item_o  (b_item)
  );

  assign out_o.valid        = b_valid;
  assign out_o.hit          = b_item.hit;
  assign out_o.new_first_x  = b_item.n1[0];
  assign out_o.new_first_y  = b_item.n1[1];
  assign out_o.new_first_z  = b_item.n1[2];
  assign out_o.new_second_x = b_item.n2[0];
  assign out_o.new_second_y = b_item.n2[1];
  assign out_o.new_second_z = b_item.n2[2];
  assign out_o.hitstop_time = b_item.hitstop;

  // a hit-stop time only comes with a hit
  `SPC_ASSERT_NOW(a_hitstop_needs_hit, out_o.valid && !out_o.hit, out_o.hitstop_time == 8'd0)
  // input back-pressure only while a result waits
  `SPC_ASSERT_NOW(a_ready_low_cause, !in_i.ready, out_o.valid && !out_o.ready)
  // a waiting result is still offered in the next cycle
  `SPC_ASSERT_NEXT(a_result_held, out_o.valid && !out_o.ready, out_o.valid)

endmodule
